>>> design/kmrd_pkg.sv
package kmrd_pkg;

	localparam int InW      = 72;
	localparam int OutW     = 24;
	localparam int SampleW  = 64;
	localparam int RowW     = 3;
	localparam int MaskW    = 16;
	localparam int PinW     = 6;
	localparam int PinsW    = 48;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 48;

	localparam logic [CfgIdxW-1:0] RegRowsInUse = 3'd0;
	localparam logic [CfgIdxW-1:0] RegColsInUse = 3'd1;
	localparam logic [CfgIdxW-1:0] RegActiveLow = 3'd2;
	localparam logic [CfgIdxW-1:0] RegPinsLow   = 3'd3;
	localparam logic [CfgIdxW-1:0] RegPinsHigh  = 3'd4;

	localparam logic [3:0] RowsInUseRst = 4'd8;
	localparam logic [4:0] ColsInUseRst = 5'd16;
	localparam logic       ActiveLowRst = 1'b1;

	typedef struct packed {
		logic [3:0]       rows_in_use;
		logic [4:0]       cols_in_use;
		logic             active_low;
		logic [PinsW-1:0] col_pins_low;
		logic [PinsW-1:0] col_pins_high;
	} cfg_t;

endpackage

>>> design/kmrd_cfg_regs.sv
module kmrd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [kmrd_pkg::CfgIdxW-1:0]   wr_index,
	input  logic [kmrd_pkg::CfgDataW-1:0]  wr_data,
	output kmrd_pkg::cfg_t                 cfg
);
	import kmrd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rows_in_use   <= RowsInUseRst;
			cfg_q.cols_in_use   <= ColsInUseRst;
			cfg_q.active_low    <= ActiveLowRst;
			cfg_q.col_pins_low  <= '0;
			cfg_q.col_pins_high <= '0;
		end else if (wr_en) begin
			case (wr_index)
				RegRowsInUse: cfg_q.rows_in_use   <= wr_data[3:0];
				RegColsInUse: cfg_q.cols_in_use   <= wr_data[4:0];
				RegActiveLow: cfg_q.active_low    <= wr_data[0];
				RegPinsLow:   cfg_q.col_pins_low  <= wr_data[PinsW-1:0];
				RegPinsHigh:  cfg_q.col_pins_high <= wr_data[PinsW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/kmrd_gather.sv
module kmrd_gather #(
	parameter int COLS = 16
) (
	input  kmrd_pkg::cfg_t                 cfg,
	input  logic [kmrd_pkg::SampleW-1:0]   sample,
	output logic [COLS-1:0]                word
);
	import kmrd_pkg::*;

	logic [SampleW-1:0] sample_pol;

	assign sample_pol = sample ^ {SampleW{cfg.active_low}};

	for (genvar c = 0; c < COLS; c++) begin : g_col
		logic [PinW-1:0] pos;
		if (c < 8) begin : g_low
			assign pos = cfg.col_pins_low[PinW*c +: PinW];
		end else begin : g_high
			assign pos = cfg.col_pins_high[PinW*(c-8) +: PinW];
		end
		assign word[c] = (5'(c) < cfg.cols_in_use) & sample_pol[pos];
	end

endmodule

>>> design/kmrd_history.sv
module kmrd_history #(
	parameter int ROWS  = 8,
	parameter int COLS  = 16,
	parameter int DEPTH = 8,
	localparam int RowAW = (ROWS > 1) ? $clog2(ROWS) : 1,
	localparam int WordW = DEPTH * COLS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [RowAW-1:0] rd_addr,
	input  logic             wr_en,
	input  logic [RowAW-1:0] wr_addr,
	input  logic [WordW-1:0] wr_data,
	output logic [WordW-1:0] rd_data
);

	logic [WordW-1:0] mem [ROWS];
	logic [WordW-1:0] mem_rd_q;
	logic [WordW-1:0] byp_data_q;
	logic [ROWS-1:0]  valid_q;
	logic             rd_valid_q;
	logic             byp_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// row valid bits stand in for clearing the array at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			byp_q      <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
				byp_q      <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_data = byp_q ? byp_data_q : (rd_valid_q ? mem_rd_q : '0);

endmodule

>>> design/key_matrix_row_debouncer.sv
// An accepted item is held in the input stage register, then in the output register that drives m_axis.
// Throughput: one item per cycle unless the output stalls; per-row history read-merge-write sets it.
// The input stage and output register hold items; s_axis_tready combinationally uses m_axis_tready.
// Reset (arst_n low, asynchronous): config returns to its defaults, the write
// slot goes to zero and the per-row valid bits clear, so all history reads zero.
module key_matrix_row_debouncer #(
	parameter int ROWS  = 8,
	parameter int COLS  = 16,
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// [2:0] row_index, [66:3] port_sample
	input  logic [kmrd_pkg::InW-1:0]      s_axis_tdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// [2:0] row_out, [18:3] pressed_mask
	output logic [kmrd_pkg::OutW-1:0]     m_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kmrd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [kmrd_pkg::CfgDataW-1:0] cfg_data
);
	import kmrd_pkg::*;

	localparam int RowAW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int SlotW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WordW = DEPTH * COLS;

	cfg_t cfg;

	logic               accept;
	logic               in_row_ok;
	logic               s1_v_q;
	logic [RowW-1:0]    row_s1;
	logic [SampleW-1:0] sample_s1;
	logic               s1_adv;
	logic               row_ok_s1;
	logic [COLS-1:0]    word;
	logic [WordW-1:0]   hist_rd;
	logic [WordW-1:0]   merged;
	logic [COLS-1:0]    mask_or;
	logic [5:0]         eff_rows;
	logic [5:0]         last_row;
	logic [SlotW-1:0]   slot_q;
	logic               m_v_q;
	logic [RowW-1:0]    out_row_q;
	logic [MaskW-1:0]   out_mask_q;

	assign cfg_ready = 1'b1;

	kmrd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign s1_adv        = s1_v_q && (!m_v_q || m_axis_tready);
	assign s_axis_tready = !s1_v_q || s1_adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_row_ok     = 6'(s_axis_tdata[RowW-1:0]) < 6'(ROWS);
	assign row_ok_s1     = 6'(row_s1) < 6'(ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_v_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1    <= s_axis_tdata[RowW-1:0];
			sample_s1 <= s_axis_tdata[RowW +: SampleW];
		end
	end

	kmrd_history #(
		.ROWS  (ROWS),
		.COLS  (COLS),
		.DEPTH (DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && in_row_ok),
		.rd_addr (RowAW'(s_axis_tdata[RowW-1:0])),
		.wr_en   (s1_adv && row_ok_s1),
		.wr_addr (RowAW'(row_s1)),
		.wr_data (merged),
		.rd_data (hist_rd)
	);

	kmrd_gather #(
		.COLS (COLS)
	) u_gather (
		.cfg    (cfg),
		.sample (sample_s1),
		.word   (word)
	);

	always_comb begin
		mask_or = '0;
		for (int d = 0; d < DEPTH; d++) begin
			merged[d*COLS +: COLS] = (SlotW'(d) == slot_q) ? word : hist_rd[d*COLS +: COLS];
			mask_or = mask_or | merged[d*COLS +: COLS];
		end
	end

	always_comb begin
		if (cfg.rows_in_use == 4'd0) begin
			eff_rows = 6'd1;
		end else if (6'(cfg.rows_in_use) > 6'(ROWS)) begin
			eff_rows = 6'(ROWS);
		end else begin
			eff_rows = 6'(cfg.rows_in_use);
		end
	end

	assign last_row = eff_rows - 6'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (s1_adv && (6'(row_s1) == last_row)) begin
			if (slot_q == SlotW'(DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SlotW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_v_q <= 1'b0;
		end else if (!m_v_q || m_axis_tready) begin
			m_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_row_q  <= row_s1;
			out_mask_q <= row_ok_s1 ? MaskW'(mask_or) : '0;
		end
	end

	assign m_axis_tvalid = m_v_q;
	assign m_axis_tdata  = {(OutW - MaskW - RowW)'(0), out_mask_q, out_row_q};

endmodule

>>> design/kmrd_checker.sv
module kmrd_checker #(
	parameter int ROWS = 8,
	parameter int COLS = 16
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tready,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [kmrd_pkg::OutW-1:0] m_axis_tdata
);
	import kmrd_pkg::*;

	localparam logic [MaskW-1:0] ColsMask = MaskW'((32'h1 << COLS) - 1);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output register empty");

	a_cols_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[RowW +: MaskW] & ~ColsMask) == '0)
		else $error("mask bit set above column count");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (32'(m_axis_tdata[RowW-1:0]) >= ROWS)
		|-> m_axis_tdata[RowW +: MaskW] == '0)
		else $error("mask set for row outside the matrix");

endmodule

bind key_matrix_row_debouncer kmrd_checker #(
	.ROWS (ROWS),
	.COLS (COLS)
) u_kmrd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> tb/key_matrix_row_debouncer_tb.sv
module key_matrix_row_debouncer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import kmrd_pkg::*;

	localparam int NumRows       = 8;
	localparam int NumCols       = 16;
	localparam int HistDepth     = 8;
	localparam int PhaseCount    = 12;
	localparam int ItemsPerPhase = 128;
	localparam int LongHold      = 300;
	localparam int SettleCycles  = 4;
	localparam int StallLimit    = 5000;
	localparam logic [CfgIdxW-1:0] RegFirstUnused = 3'd5;

	// columns 0..7 and 8..15, six bits each, column 0 lowest
	localparam logic [PinsW-1:0] DirPinsLo =
		{6'd56, 6'd55, 6'd32, 6'd31, 6'd8, 6'd7, 6'd63, 6'd0};
	localparam logic [PinsW-1:0] DirPinsHi =
		{6'd24, 6'd40, 6'd48, 6'd47, 6'd16, 6'd15, 6'd62, 6'd1};

	typedef struct packed {
		logic [SampleW-1:0] sample;
		logic [RowW-1:0]    row;
	} row_sample_t;

	typedef struct packed {
		logic [MaskW-1:0] mask;
		logic [RowW-1:0]  row;
	} row_mask_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic [InW-1:0]      s_axis_tdata  = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [OutW-1:0]     m_axis_tdata;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [CfgIdxW-1:0]  cfg_index     = '0;
	logic [CfgDataW-1:0] cfg_data      = '0;

	key_matrix_row_debouncer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// predictor copy of the block's registers and history
	logic [3:0]       rows_cfg    = RowsInUseRst;
	logic [4:0]       cols_cfg    = ColsInUseRst;
	logic             inv_cfg     = ActiveLowRst;
	logic [PinsW-1:0] pins_lo_cfg = '0;
	logic [PinsW-1:0] pins_hi_cfg = '0;
	logic [MaskW-1:0] key_history [NumRows][HistDepth] = '{default: '0};
	int               ring_slot   = 0;

	row_sample_t sample_q[$];
	row_mask_t   mask_expect_q[$];

	int send_gap_max = 0;
	int sink_gap_max = 0;
	int hold_asked   = 0;

	int errors        = 0;
	int masks_checked = 0;
	int masks_nonzero = 0;
	int items_sent    = 0;
	int reg_writes    = 0;

	wire in_take  = s_axis_tvalid && s_axis_tready;
	wire out_take = m_axis_tvalid && m_axis_tready;
	wire cfg_take = cfg_valid && cfg_ready;
	logic in_took  = 1'b0;
	logic out_took = 1'b0;

	function automatic logic [MaskW-1:0] column_word(input logic [SampleW-1:0] raw);
		logic [SampleW-1:0] s;
		logic [MaskW-1:0]   w;
		logic [PinW-1:0]    pos;
		s = raw ^ {SampleW{inv_cfg}};
		w = '0;
		for (int c = 0; c < NumCols; c++) begin
			if (c < int'(cols_cfg)) begin
				pos = (c < 8) ? pins_lo_cfg[PinW*c +: PinW] : pins_hi_cfg[PinW*(c-8) +: PinW];
				w[c] = s[pos];
			end
		end
		return w;
	endfunction

	function automatic row_mask_t debounce_row(input row_sample_t it);
		row_mask_t res;
		int        last;
		if (rows_cfg == 0)
			last = 0;
		else if (rows_cfg > NumRows)
			last = NumRows - 1;
		else
			last = int'(rows_cfg) - 1;
		res.row  = it.row;
		res.mask = '0;
		key_history[it.row][ring_slot] = column_word(it.sample);
		for (int d = 0; d < HistDepth; d++)
			res.mask |= key_history[it.row][d];
		if (int'(it.row) == last)
			ring_slot = (ring_slot + 1) % HistDepth;
		return res;
	endfunction

	function automatic logic [SampleW-1:0] sparse_keys();
		return {$urandom, $urandom} & {$urandom, $urandom} &
			{$urandom, $urandom} & {$urandom, $urandom};
	endfunction

	task automatic queue_item(input int row, input logic [SampleW-1:0] sample);
		row_sample_t it;
		it.row    = row[RowW-1:0];
		it.sample = sample;
		sample_q.push_back(it);
		items_sent++;
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			RegRowsInUse: rows_cfg    = val[3:0];
			RegColsInUse: cols_cfg    = val[4:0];
			RegActiveLow: inv_cfg     = val[0];
			RegPinsLow:   pins_lo_cfg = val;
			RegPinsHigh:  pins_hi_cfg = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (sample_q.size() > 0 || s_axis_tvalid || mask_expect_q.size() > 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// sender
	int send_wait = 0;
	always @(negedge clk) begin
		if (!s_axis_tvalid || in_took) begin
			if (send_wait > 0) begin
				send_wait--;
				s_axis_tvalid <= 1'b0;
			end else if (sample_q.size() > 0) begin
				s_axis_tdata  <= InW'(sample_q.pop_front());
				s_axis_tvalid <= 1'b1;
				send_wait = $urandom_range(0, send_gap_max);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: per-transaction stall, plus a long hold on request
	int sink_wait   = 0;
	int hold_left   = 0;
	int hold_served = 0;
	always @(negedge clk) begin
		if (hold_served != hold_asked) begin
			hold_served++;
			hold_left = LongHold;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			if (out_took)
				sink_wait = $urandom_range(0, sink_gap_max);
			if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// monitor and checker
	row_mask_t got_mask;
	row_mask_t want_mask;
	always @(posedge clk) begin
		in_took  <= in_take;
		out_took <= out_take;
		if (arst_n && in_take)
			mask_expect_q.push_back(debounce_row(row_sample_t'(s_axis_tdata[RowW+SampleW-1:0])));
		if (arst_n && out_take) begin
			got_mask = row_mask_t'(m_axis_tdata[RowW+MaskW-1:0]);
			if (mask_expect_q.size() == 0) begin
				errors++;
				$error("unexpected result: row_out %0d pressed_mask %h",
					got_mask.row, got_mask.mask);
			end else begin
				want_mask = mask_expect_q.pop_front();
				masks_checked++;
				if (want_mask.mask != '0)
					masks_nonzero++;
				if (got_mask.row !== want_mask.row) begin
					errors++;
					$error("row_out expected %0d got %0d", want_mask.row, got_mask.row);
				end
				if (got_mask.mask !== want_mask.mask) begin
					errors++;
					$error("pressed_mask expected %h got %h", want_mask.mask, got_mask.mask);
				end
			end
		end
	end

	// watchdog
	int idle_run = 0;
	always @(posedge clk) begin
		if (in_take || out_take || cfg_take || !arst_n)
			idle_run = 0;
		else
			idle_run++;
		if (idle_run >= StallLimit) begin
			$display("key_matrix_row_debouncer regression: fail");
			$finish;
		end
	end

	initial begin
		logic [3:0]         rows_val;
		logic [4:0]         cols_val;
		logic               inv_val;
		logic [PinsW-1:0]   lo_val;
		logic [PinsW-1:0]   hi_val;
		logic [CfgDataW-1:0] junk;
		logic [SampleW-1:0] pressed;
		logic [SampleW-1:0] held_keys [NumRows];
		int                 last_row;
		int                 queued;

		foreach (held_keys[r])
			held_keys[r] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// defaults: every column reads port bit 0, active low
		queue_item(0, '0);
		queue_item(7, '1);
		settle();

		// single row: press shows at once, release after a full history of clean samples
		write_reg(RegRowsInUse, 1);
		write_reg(RegColsInUse, 16);
		write_reg(RegActiveLow, 0);
		write_reg(RegPinsLow, DirPinsLo);
		write_reg(RegPinsHigh, DirPinsHi);
		write_reg(RegFirstUnused, '1);
		queue_item(0, '1);
		for (int i = 0; i < HistDepth; i++)
			queue_item(0, '0);
		queue_item(3, 64'h8000_0000_0000_0001);
		settle();

		// zero rows acts as one, zero columns gives an empty word
		write_reg(RegRowsInUse, 0);
		write_reg(RegColsInUse, 0);
		queue_item(0, '1);
		queue_item(2, '1);
		settle();

		// rows and columns above range saturate
		write_reg(RegRowsInUse, 15);
		write_reg(RegColsInUse, 31);
		write_reg(RegActiveLow, 1);
		queue_item(7, '0);
		queue_item(7, '1);
		queue_item(6, {4{16'haaaa}});
		queue_item(5, {4{16'h5555}});

		for (int p = 0; p < PhaseCount; p++) begin
			settle();
			case (p % 6)
				0: rows_val = 4'd8;
				1: rows_val = 4'd1;
				2: rows_val = 4'd0;
				3: rows_val = 4'd15;
				default: rows_val = 4'($urandom_range(0, 15));
			endcase
			case (p % 5)
				0: cols_val = 5'd16;
				1: cols_val = 5'd1;
				2: cols_val = 5'd0;
				3: cols_val = 5'd31;
				default: cols_val = 5'($urandom_range(0, 31));
			endcase
			inv_val = p[1];
			if (p == 0) begin
				lo_val = '0;
				hi_val = '0;
			end else if (p == 1) begin
				lo_val = '1;
				hi_val = '1;
			end else begin
				lo_val = PinsW'({$urandom, $urandom});
				hi_val = PinsW'({$urandom, $urandom});
			end
			// unused upper data bits carry junk on odd phases
			junk = (p % 2) ? CfgDataW'({$urandom, $urandom}) : '0;
			write_reg(RegRowsInUse, {junk[CfgDataW-1:4], rows_val});
			write_reg(RegColsInUse, {junk[CfgDataW-1:5], cols_val});
			write_reg(RegActiveLow, {junk[CfgDataW-1:1], inv_val});
			write_reg(RegPinsLow, lo_val);
			write_reg(RegPinsHigh, hi_val);
			write_reg(RegFirstUnused + CfgIdxW'($urandom_range(0, 2)), junk);

			send_gap_max = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 3 : 15;
			sink_gap_max = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 15 : (p % 4 == 2) ? 2 : 7;
			if (rows_val == 0)
				last_row = 0;
			else if (rows_val > NumRows)
				last_row = NumRows - 1;
			else
				last_row = int'(rows_val) - 1;

			queued = 0;
			while (queued < ItemsPerPhase) begin
				if ($urandom_range(0, 9) == 0) begin
					queue_item($urandom_range(0, NumRows - 1), {$urandom, $urandom});
					queued++;
				end else begin
					for (int r = 0; r <= last_row; r++) begin
						if (r > 0 && $urandom_range(0, 19) == 0)
							break;
						if ($urandom_range(0, 15) == 0)
							held_keys[r] = ($urandom_range(0, 3) == 0) ? '0 : sparse_keys();
						pressed = held_keys[r];
						if ($urandom_range(0, 3) == 0)
							pressed |= sparse_keys();
						queue_item(r, inv_val ? ~pressed : pressed);
						queued++;
					end
				end
			end
			if (p == 4)
				hold_asked++;
		end

		settle();
		$display("covered %0d row samples, %0d register writes over %0d phases",
			items_sent, reg_writes, PhaseCount + 4);
		$display("%0d masks compared, %0d with keys held", masks_checked, masks_nonzero);
		if (errors == 0)
			$display("key_matrix_row_debouncer regression: pass");
		else
			$display("key_matrix_row_debouncer regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
design/kmrd_pkg.sv
design/kmrd_cfg_regs.sv
design/kmrd_gather.sv
design/kmrd_history.sv
design/key_matrix_row_debouncer.sv
design/kmrd_checker.sv
tb/key_matrix_row_debouncer_tb.sv
